/* src/a1t_pkg.sv */
// ---------------------------------------------------------------------------
// a1t_pkg: shared types and tables for the ASN.1 time string converter
// parse phases, sequencer states, day-of-year table and fixed constants
// ---------------------------------------------------------------------------
`default_nettype none
package a1t_pkg;

    localparam int unsigned CyWidth = 14;
    localparam int unsigned EpochWidth = 39;
    localparam logic [CyWidth-1:0] CyReset = 14'd2024;

    typedef enum logic [2:0] {
        PH_DIGITS,
        PH_FRAC,
        PH_POST_FRAC,
        PH_OFF_H1,
        PH_OFF_H2,
        PH_OFF_M1,
        PH_OFF_M2,
        PH_END
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_W0,
        S_W1,
        S_CHK,
        S_D0,
        S_D1,
        S_D2,
        S_D3
    } t_state;

    // days from march 1 to the first of month m (march-based year)
    function automatic logic [8:0] doy_of(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd3:    v = 9'd0;
            4'd4:    v = 9'd31;
            4'd5:    v = 9'd61;
            4'd6:    v = 9'd92;
            4'd7:    v = 9'd122;
            4'd8:    v = 9'd153;
            4'd9:    v = 9'd184;
            4'd10:   v = 9'd214;
            4'd11:   v = 9'd245;
            4'd12:   v = 9'd275;
            4'd1:    v = 9'd306;
            4'd2:    v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/asn1_time_string_to_epoch.sv */
// ---------------------------------------------------------------------------
// asn1_time_string_to_epoch: ASN.1 UTCTime / GeneralizedTime to epoch seconds
// parses one character per request and converts the date on the last one
// ---------------------------------------------------------------------------
// rate: one character per cycle while idle; after the last character the sequencer
//   steps through S_W0, S_W1, S_CHK, S_D0, S_D1, S_D2 and S_D3 (S_D0 to S_D2 are skipped
//   when the field checks already fail) and takes no new character until the result
//   is registered; S_D3 waits while a previous result still waits for i_m_tready
// reset: synchronous active low, current_year returns to 2024, parse cleared
// ---------------------------------------------------------------------------
`default_nettype none
module asn1_time_string_to_epoch (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [a1t_pkg::CyWidth-1:0]  i_cfg_wdata,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [7:0]                   i_s_tdata,   // char_code
    input  wire logic                         i_s_tlast,   // last_char
    input  wire logic                         i_s_tuser,   // general_format
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [39:0]                       o_m_tdata    // epoch_seconds [39:1], time_valid [0]
);
    import a1t_pkg::*;

    t_state r_state, n_state;
    logic [CyWidth-1:0] r_cy;

    logic [5:0] r_ccnt, n_ccnt;
    t_phase     r_ph, n_ph;
    logic       r_fmt, n_fmt;
    logic [4:0] r_dcnt, n_dcnt;
    logic [13:0] r_yv, n_yv;
    logic [6:0] r_f [5];
    logic [6:0] n_f [5];
    logic [2:0] r_sc, n_sc;
    logic       r_neg, n_neg;
    logic [6:0] r_oh, n_oh, r_om, n_om;
    logic       r_err, n_err;

    logic [7:0]  r_q, n_q;
    logic [13:0] r_cent, n_cent;
    logic [13:0] r_year, n_year;
    logic [3:0]  r_mon, n_mon;
    logic signed [24:0] r_days, n_days;
    logic signed [41:0] r_t, n_t;
    logic        r_ok, n_ok;
    logic        r_ov, n_ov;
    logic [39:0] r_od, n_od;
    logic        clr;

    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic        acc, fmt_now, dig;
    logic [3:0]  d;
    logic [7:0]  c;
    logic [4:0]  ylen, rel;
    logic [2:0]  k;
    logic signed [16:0] cur, cent, yys, wy, yr;
    logic [13:0] mon_v, yy;
    logic        lok, pok, rok;
    logic [18:0] hms;
    logic [17:0] off;
    logic signed [41:0] tt;

    assign o_s_tready = (r_state == S_IDLE);
    assign acc = i_s_tvalid && o_s_tready;
    assign c = i_s_tdata;
    assign dig = (c >= 8'h30) && (c <= 8'h39);
    assign d = 4'(c - 8'h30);
    assign fmt_now = (r_ccnt == 6'd0) ? i_s_tuser : r_fmt;
    assign ylen = fmt_now ? 5'd4 : 5'd2;
    assign rel = r_dcnt - ylen;
    assign k = rel[3:1];
    assign yy = r_year - ((r_mon <= 4'd2) ? 14'd1 : 14'd0);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata = r_od;

    always_comb begin
        n_ccnt = r_ccnt; n_ph = r_ph; n_fmt = r_fmt; n_dcnt = r_dcnt;
        n_yv = r_yv; n_f = r_f; n_sc = r_sc; n_neg = r_neg;
        n_oh = r_oh; n_om = r_om; n_err = r_err;
        n_state = r_state; n_q = r_q; n_cent = r_cent; n_year = r_year;
        n_mon = r_mon; n_days = r_days; n_t = r_t; n_ok = r_ok;
        n_ov = r_ov && !i_m_tready; n_od = r_od;
        mul_a = '0; mul_b = '0; clr = 1'b0;
        cur = '0; cent = '0; yys = '0; wy = '0; yr = '0; mon_v = '0;
        lok = 1'b0; pok = 1'b0; rok = 1'b0; hms = '0; off = '0; tt = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_fmt = fmt_now;
                    if (r_ccnt != 6'd63) n_ccnt = r_ccnt + 6'd1;
                    if (c == 8'h00) begin
                        n_err = 1'b1;
                    end else begin
                        case (r_ph)
                            PH_DIGITS, PH_POST_FRAC: begin
                                if (r_ph == PH_DIGITS && dig) begin
                                    if (r_dcnt < ylen) begin
                                        n_yv = 14'(r_yv * 14'd10 + 14'(d));
                                    end else if (r_dcnt < ylen + 5'd10) begin
                                        if (!r_dcnt[0]) n_f[k] = 7'(d * 7'd10);
                                        else n_f[k] = r_f[k] + 7'(d);
                                    end
                                    if (r_dcnt != 5'd31) n_dcnt = r_dcnt + 5'd1;
                                end else if (r_ph == PH_DIGITS && c == 8'h2e) begin
                                    n_ph = PH_FRAC; n_sc = '0;
                                end else if (c == 8'h5a) begin
                                    n_ph = PH_END;
                                end else if (c == 8'h2b || c == 8'h2d) begin
                                    n_neg = (c == 8'h2d); n_ph = PH_OFF_H1;
                                end else begin
                                    n_err = 1'b1;
                                end
                            end
                            PH_FRAC: begin
                                n_sc = r_sc + 3'd1;
                                if (n_sc >= 3'd4) n_ph = PH_POST_FRAC;
                            end
                            PH_OFF_H1: begin
                                if (!dig) n_err = 1'b1;
                                else begin n_oh = 7'(d * 7'd10); n_ph = PH_OFF_H2; end
                            end
                            PH_OFF_H2: begin
                                if (!dig) n_err = 1'b1;
                                else begin
                                    n_oh = r_oh + 7'(d);
                                    if (n_oh > 7'd24) n_err = 1'b1;
                                    n_ph = PH_OFF_M1;
                                end
                            end
                            PH_OFF_M1: begin
                                if (!dig) n_err = 1'b1;
                                else begin n_om = 7'(d * 7'd10); n_ph = PH_OFF_M2; end
                            end
                            PH_OFF_M2: begin
                                if (!dig) n_err = 1'b1;
                                else begin n_om = r_om + 7'(d); n_ph = PH_END; end
                            end
                            default: n_err = 1'b1;
                        endcase
                    end
                    if (i_s_tlast) n_state = S_W0;
                end
            end
            S_W0: begin
                mul_a = 25'(r_cy); mul_b = 18'sd5243;
                n_q = mul_p[26:19];
                n_state = S_W1;
            end
            S_W1: begin
                mul_a = 25'(r_q); mul_b = 18'sd100;
                n_cent = mul_p[13:0];
                n_state = S_CHK;
            end
            S_CHK: begin
                cent = 17'(r_cent);
                cur = 17'(r_cy) - cent;
                yys = 17'(r_yv);
                if (cur < 17'sd40) begin
                    if (yys < cur) wy = cent + yys;
                    else if (yys > 17'sd60 + cur) wy = cent - 17'sd100 + yys;
                    else wy = cent + yys;
                end else if (yys < cur && yys > cur - 17'sd40) begin
                    wy = cent + yys;
                end else if (yys < cur) begin
                    wy = cent + 17'sd100 + yys;
                end else begin
                    wy = cent + yys;
                end
                yr = 17'sd1900;
                mon_v = 14'(r_f[0]);
                if (r_fmt) begin
                    lok = (r_ccnt >= 6'd8) && (r_ccnt < 6'd30);
                    if (r_dcnt == 5'd2) mon_v = r_yv;
                    else if (r_dcnt != 5'd0) begin
                        if (r_dcnt < 5'd4 || r_dcnt > 5'd14 || r_dcnt[0]) lok = 1'b0;
                        yr = 17'(r_yv);
                    end
                end else begin
                    lok = (r_ccnt >= 6'd6) && (r_ccnt < 6'd28)
                        && !r_dcnt[0] && (r_dcnt <= 5'd12);
                    if (r_dcnt >= 5'd2) yr = wy;
                end
                pok = (r_ph == PH_DIGITS) || (r_ph == PH_POST_FRAC)
                    || (r_ph == PH_END) || (r_ph == PH_OFF_M1);
                rok = (yr >= 17'sd1900) && (yr <= 17'sd11899)
                    && (mon_v >= 14'd1) && (mon_v <= 14'd12)
                    && (r_f[1] >= 7'd1) && (r_f[1] <= 7'd31)
                    && (r_f[2] <= 7'd23) && (r_f[3] <= 7'd59) && (r_f[4] <= 7'd59);
                n_year = yr[13:0];
                n_mon = mon_v[3:0];
                n_ok = !r_err && lok && pok && rok;
                n_state = n_ok ? S_D0 : S_D3;
            end
            S_D0: begin
                mul_a = 25'(yy); mul_b = 18'sd5243;
                n_q = mul_p[26:19];
                n_state = S_D1;
            end
            S_D1: begin
                mul_a = 25'(yy); mul_b = 18'sd365;
                n_days = mul_p[24:0] + 25'(yy >> 2) - 25'(r_q) + 25'(r_q >> 2)
                    + 25'(doy_of(r_mon)) + 25'(r_f[1]) - 25'sd1 - 25'sd719468;
                n_state = S_D2;
            end
            S_D2: begin
                mul_a = r_days; mul_b = 18'sd86400;
                hms = 19'(r_f[2]) * 19'd3600 + 19'(r_f[3]) * 19'd60 + 19'(r_f[4]);
                n_t = mul_p[41:0] + 42'(hms);
                n_state = S_D3;
            end
            S_D3: begin
                off = 18'(r_oh) * 18'd3600 + 18'(r_om) * 18'd60;
                tt = r_neg ? r_t + 42'(off) : r_t - 42'(off);
                if (!r_ov || i_m_tready) begin
                    rok = r_ok && (tt >= -42'sd274877906944)
                        && (tt <= 42'sd274877906943);
                    n_ov = 1'b1;
                    n_od = rok ? {tt[EpochWidth-1:0], 1'b1} : 40'd0;
                    clr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (clr) begin
            n_ccnt = '0; n_ph = PH_DIGITS; n_fmt = 1'b0; n_dcnt = '0; n_yv = '0;
            n_f[0] = 7'd1; n_f[1] = 7'd1; n_f[2] = '0; n_f[3] = '0; n_f[4] = '0;
            n_sc = '0; n_neg = 1'b0; n_oh = '0; n_om = '0; n_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cy <= CyReset;
            r_ccnt <= '0; r_ph <= PH_DIGITS; r_fmt <= 1'b0; r_dcnt <= '0; r_yv <= '0;
            r_f[0] <= 7'd1; r_f[1] <= 7'd1; r_f[2] <= '0; r_f[3] <= '0; r_f[4] <= '0;
            r_sc <= '0; r_neg <= 1'b0; r_oh <= '0; r_om <= '0; r_err <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cy <= i_cfg_wdata;
            r_ccnt <= n_ccnt; r_ph <= n_ph; r_fmt <= n_fmt; r_dcnt <= n_dcnt;
            r_yv <= n_yv; r_f <= n_f; r_sc <= n_sc; r_neg <= n_neg;
            r_oh <= n_oh; r_om <= n_om; r_err <= n_err;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_cent <= n_cent; r_year <= n_year; r_mon <= n_mon;
        r_days <= n_days; r_t <= n_t; r_ok <= n_ok; r_od <= n_od;
    end

endmodule
`default_nettype wire

/* src/a1t_checker.sv */
// ---------------------------------------------------------------------------
// a1t_checker: port-level checks for the ASN.1 time converter
// watches the result stream and the request handshake
// ---------------------------------------------------------------------------
`default_nettype none
module a1t_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        i_s_tlast,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[39:1] == 39'd0)
        else $error("invalid result with nonzero epoch");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("request taken during conversion");
endmodule

bind asn1_time_string_to_epoch a1t_checker u_a1t_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready), .i_s_tlast(i_s_tlast), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);
`default_nettype wire

/* dv/tb_asn1_time_string_to_epoch.sv */
// ---------------------------------------------------------------------------
// tb_asn1_time_string_to_epoch: self-checking bench for the time converter
// feeds utctime and generalizedtime strings character by character, predicts
// validity and epoch seconds per string, and compares every result in order
// ---------------------------------------------------------------------------
`default_nettype none
module tb_asn1_time_string_to_epoch;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       gen;
    } t_char_req;

    typedef struct packed {
        logic        ok;
        logic [38:0] secs;
    } t_epoch;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [a1t_pkg::CyWidth-1:0] i_cfg_wdata = '0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [7:0]                  i_s_tdata = '0;
    logic                        i_s_tlast = 1'b0;
    logic                        i_s_tuser = 1'b0;
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b0;
    logic [39:0]                 o_m_tdata;

    asn1_time_string_to_epoch dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_char_req pending_chars[$];
    t_epoch    expected_epochs[$];
    int        n_errors = 0;
    int        n_strings = 0;
    int        n_valid = 0;
    int        n_chars = 0;
    bit        hold_sender = 1'b0;

    // predictor state
    logic [13:0] cur_year;
    int          p_count, p_digits, p_suffix, p_year;
    int          p_fields[5];
    int          p_offh, p_offm;
    bit          p_gen, p_neg, p_err;
    a1t_pkg::t_phase p_phase;

    function automatic void clear_parse();
        p_count = 0; p_digits = 0; p_suffix = 0; p_year = 0;
        p_fields = '{1, 1, 0, 0, 0};
        p_offh = 0; p_offm = 0; p_gen = 0; p_neg = 0; p_err = 0;
        p_phase = a1t_pkg::PH_DIGITS;
    endfunction

    function automatic int window_century(int yy);
        int cy, cur, cent;
        cy = cur_year;
        cur = cy % 100;
        cent = cy - cur;
        if (cur < 40) begin
            if (yy < cur) return cent + yy;
            if (yy > 100 - (40 - cur)) return cent - 100 + yy;
        end else if (yy < cur && yy > cur - 40) begin
            return cent + yy;
        end
        if (yy < cur) return cent + 100 + yy;
        return cent + yy;
    endfunction

    function automatic longint civil_days(longint y, longint m);
        longint yy, era, yoe, mp, doy, doe;
        yy = y - (m <= 2 ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        mp = m > 2 ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic void add_digit(int d);
        int ylen, k;
        ylen = p_gen ? 4 : 2;
        if (p_digits < ylen) begin
            p_year = (p_year * 10 + d) & 16'h3fff;
        end else if (p_digits < ylen + 10) begin
            k = (p_digits - ylen) >> 1;
            if ((p_digits & 1) == 0) p_fields[k] = d * 10;
            else p_fields[k] = (p_fields[k] + d) & 8'h7f;
        end
        if (p_digits < 31) p_digits++;
    endfunction

    function automatic void parse_char(int c);
        bit dig;
        int d;
        dig = c >= 8'h30 && c <= 8'h39;
        d = c - 8'h30;
        if (c == 0) begin
            p_err = 1;
            return;
        end
        if (p_phase == a1t_pkg::PH_DIGITS && dig) begin
            add_digit(d);
            return;
        end
        if (p_phase == a1t_pkg::PH_DIGITS && c == "." ) begin
            p_phase = a1t_pkg::PH_FRAC;
            p_suffix = 0;
            return;
        end
        case (p_phase)
            a1t_pkg::PH_DIGITS, a1t_pkg::PH_POST_FRAC: begin
                if (c == "Z") p_phase = a1t_pkg::PH_END;
                else if (c == "+" || c == "-") begin
                    p_neg = (c == "-");
                    p_phase = a1t_pkg::PH_OFF_H1;
                end else p_err = 1;
            end
            a1t_pkg::PH_FRAC: begin
                p_suffix++;
                if (p_suffix >= 4) p_phase = a1t_pkg::PH_POST_FRAC;
            end
            a1t_pkg::PH_OFF_H1: begin
                if (!dig) p_err = 1;
                else begin
                    p_offh = d * 10;
                    p_phase = a1t_pkg::PH_OFF_H2;
                end
            end
            a1t_pkg::PH_OFF_H2: begin
                if (!dig) p_err = 1;
                else begin
                    p_offh += d;
                    if (p_offh > 24) p_err = 1;
                    p_phase = a1t_pkg::PH_OFF_M1;
                end
            end
            a1t_pkg::PH_OFF_M1: begin
                if (!dig) p_err = 1;
                else begin
                    p_offm = d * 10;
                    p_phase = a1t_pkg::PH_OFF_M2;
                end
            end
            a1t_pkg::PH_OFF_M2: begin
                if (!dig) p_err = 1;
                else begin
                    p_offm += d;
                    p_phase = a1t_pkg::PH_END;
                end
            end
            default: p_err = 1;
        endcase
    endfunction

    function automatic t_epoch convert_string();
        t_epoch r;
        longint yr, mon, dy, hr, mi, se, t;
        bit bad;
        r = '0;
        bad = p_err;
        yr = 1900; mon = p_fields[0]; dy = p_fields[1];
        hr = p_fields[2]; mi = p_fields[3]; se = p_fields[4];
        if (p_gen) begin
            if (p_count < 8 || p_count >= 30) bad = 1;
            if (p_digits == 2) mon = p_year;
            else if (p_digits != 0) begin
                if (p_digits < 4 || p_digits > 14 || (p_digits & 1)) bad = 1;
                yr = p_year;
            end
        end else begin
            if (p_count < 6 || p_count >= 28) bad = 1;
            if ((p_digits & 1) || p_digits > 12) bad = 1;
            if (p_digits >= 2) yr = window_century(p_year);
        end
        if (!(p_phase inside {a1t_pkg::PH_DIGITS, a1t_pkg::PH_POST_FRAC,
                              a1t_pkg::PH_END, a1t_pkg::PH_OFF_M1})) bad = 1;
        if (yr < 1900 || yr > 11899) bad = 1;
        if (mon < 1 || mon > 12 || dy < 1 || dy > 31) bad = 1;
        if (hr > 23 || mi > 59 || se > 59) bad = 1;
        if (bad) return r;
        t = (civil_days(yr, mon) + dy - 1) * 86400 + hr * 3600 + mi * 60 + se;
        t = p_neg ? t + (p_offh * 3600 + p_offm * 60) : t - (p_offh * 3600 + p_offm * 60);
        if (t < -(64'sd1 <<< 38) || t > (64'sd1 <<< 38) - 1) return r;
        r.ok = 1'b1;
        r.secs = t[38:0];
        return r;
    endfunction

    function automatic void predict_char(t_char_req q);
        if (p_count == 0) p_gen = q.gen;
        if (p_count < 63) p_count++;
        parse_char(q.ch);
        if (q.last) begin
            expected_epochs.push_back(convert_string());
            clear_parse();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // handshakes seen at the last rising edge
    bit in_acc = 1'b0;
    bit out_acc = 1'b0;

    // driver
    int send_gap = 0;
    int recv_gap = 0;
    always @(negedge i_clk) begin
        t_char_req q;
        if (i_rst_n) begin
            if (i_s_tvalid && !in_acc) begin
                // hold the request until it is taken
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_chars.size() > 0 && !hold_sender) begin
                q = pending_chars.pop_front();
                i_s_tdata <= q.ch;
                i_s_tlast <= q.last;
                i_s_tuser <= q.gen;
                i_s_tvalid <= 1'b1;
                send_gap <= $urandom_range(0, 3);
            end else begin
                i_s_tvalid <= 1'b0;
            end
            if (out_acc) recv_gap = $urandom_range(0, 3);
            else if (recv_gap > 0) recv_gap = recv_gap - 1;
            i_m_tready <= (recv_gap == 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_epoch w;
        in_acc = i_rst_n && i_s_tvalid && o_s_tready;
        out_acc = i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_char('{i_s_tdata, i_s_tlast, i_s_tuser});
                n_chars++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_epochs.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, '0);
                end else begin
                    w = expected_epochs.pop_front();
                    n_strings++;
                    if (w.ok) n_valid++;
                    if (o_m_tdata[0] !== w.ok)
                        report_mismatch("time_valid", o_m_tdata, w);
                    else if (o_m_tdata[39:1] !== w.secs)
                        report_mismatch("epoch_seconds", o_m_tdata, w);
                end
            end
        end
    end

    // zpos names a character sent as a zero byte instead
    task automatic push_string(input string s, input bit gen, input int zpos = -1);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back('{(i == zpos) ? 8'h00 : s[i], i == s.len() - 1, gen});
    endtask

    function automatic string two_dig(int v);
        return $sformatf("%02d", v);
    endfunction

    function automatic string random_string(output bit gen, output int zpos);
        string s, sign;
        int kind;
        zpos = -1;
        gen = $urandom_range(0, 1);
        kind = $urandom_range(0, 9);
        if (gen) s = $sformatf("%04d", $urandom_range(0, 9999));
        else s = two_dig($urandom_range(0, 99));
        s = {s, two_dig($urandom_range(1, 12)), two_dig($urandom_range(1, 31)),
             two_dig($urandom_range(0, 23)), two_dig($urandom_range(0, 59))};
        if ($urandom_range(0, 3) != 0) s = {s, two_dig($urandom_range(0, 59))};
        if ($urandom_range(0, 4) == 0) begin
            s = {s, "."};
            for (int i = 0; i < 4; i++) s = $sformatf("%s%c", s, $urandom_range(1, 255));
        end
        sign = $urandom_range(0, 1) ? "+" : "-";
        case ($urandom_range(0, 3))
            0: s = {s, "Z"};
            1: s = {s, sign, two_dig($urandom_range(0, 25)), two_dig($urandom_range(0, 99))};
            2: s = {s, sign, two_dig($urandom_range(0, 25))};
            default: ;
        endcase
        if (kind == 0) begin
            // corrupt one character anywhere
            s.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(1, 255)));
        end else if (kind == 1) begin
            s = s.substr(0, $urandom_range(0, s.len() - 1));
        end else if (kind == 2) begin
            zpos = $urandom_range(0, s.len() - 1);
        end else if (kind == 3) begin
            s = $sformatf("%s%c", s, $urandom_range(1, 255));
        end
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_chars.size() > 0 || expected_epochs.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_year(input logic [13:0] y);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wdata <= y;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_year = y;
    endtask

    initial begin
        bit g;
        int z;
        string s;
        logic [13:0] years[6];
        cur_year = a1t_pkg::CyReset;
        clear_parse();
        years = '{14'd1970, 14'd2024, 14'd2039, 14'd2075, 14'd9999, 14'd16383};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_string("700101000000Z", 0);
        push_string("19700101000000Z", 1);
        push_string("991231235959Z", 0);
        push_string("000229120000+0530", 0);
        push_string("20240131235959.1234-2400", 1);
        push_string("0215", 1);
        push_string("12345678", 1);
        push_string("240230", 0);
        push_string("2401320000Z", 0);
        push_string("119991231235959", 1);
        push_string("2401010000+25", 0);
        push_string("2401010000+1", 0);
        push_string("2401010000+12a0", 0);
        push_string("2401010000Zx", 0);
        push_string("2401010000Z", 0, 6);
        push_string("2401010000.ab", 0);
        push_string("2401010000.\377\200\001 Z", 0);
        while (pending_chars.size() > 0) @(posedge i_clk);
        hold_sender = 1'b1;
        push_string("9999123123595", 1);
        push_string("ZZZZZZZZ", 1);
        while (expected_epochs.size() > 0 || i_s_tvalid) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_drained();

        foreach (years[k]) begin
            write_year(years[k]);
            for (int i = 0; i < 2; i++) begin
                s = random_string(g, z);
                push_string(s, g, z);
            end
            while (pending_chars.size() > 0) @(posedge i_clk);
        end
        write_year($urandom_range(1970, 9999));
        for (int i = 0; i < 100; i++) begin
            pending_chars.push_back('{8'($urandom_range(0, 255)),
                                      ($urandom_range(0, 15) == 0),
                                      1'($urandom_range(0, 1))});
            while (pending_chars.size() > 0) @(posedge i_clk);
        end
        pending_chars.push_back('{8'h5a, 1'b1, 1'b0});
        wait_drained();

        $display("strings checked: %0d (%0d valid) from %0d characters",
                 n_strings, n_valid, n_chars);
        $display("current_year settings included 1970, 9999 and the 14-bit maximum");
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
